// File: rtl/wtm_pkg.sv
// Shared constants, operation and register codes, and the divider state type
// of the windowed throughput meter. Depends on nothing.
`timescale 1ns / 1ps

package wtm_pkg;

	// Field widths of the item, result and configuration ports.
	localparam int OP_BITS    = 2;
	localparam int DELTA_BITS = 31;
	localparam int TIME_BITS  = 32;
	localparam int TOTAL_BITS = 48;
	localparam int RATE_BITS  = 58;
	localparam int CFG_BITS   = 32;
	localparam int ADDR_BITS  = 3;

	// Default width of the running byte counters.
	localparam int COUNT_BITS_DEFAULT = 48;

	// Jobs held between the classifying front and the dividing back.
	localparam int JOB_QUEUE_DEPTH = 4;

	// Milliseconds per second, as a multiplier of the byte count.
	localparam int MS_BITS = 10;
	localparam logic [MS_BITS-1:0] MS_PER_SEC = 10'd1000;

	localparam logic [RATE_BITS-1:0] RATE_MAX = '1;

	// Operation codes.
	localparam logic [OP_BITS-1:0] OP_START   = 2'd0;
	localparam logic [OP_BITS-1:0] OP_ADD     = 2'd1;
	localparam logic [OP_BITS-1:0] OP_AVERAGE = 2'd2;

	// Register indexes, taken from address bit 2.
	localparam logic REG_MIN_BYTES = 1'b0;
	localparam logic REG_MIN_MS    = 1'b1;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} bk_state_t;

endpackage

// File: rtl/wtm_fifo.sv
// Small first-in first-out queue of register slots, carrying jobs from the
// front to the back. Depends on nothing.
`timescale 1ns / 1ps

module wtm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rdata = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/wtm_front.sv
// Front of the meter: accepts items, keeps the byte counters and time marks,
// and turns each item into a division job. Depends on wtm_pkg.
`timescale 1ns / 1ps

module wtm_front #(
	parameter int COUNT_BITS  = wtm_pkg::COUNT_BITS_DEFAULT,
	parameter int AMOUNT_BITS = wtm_pkg::TOTAL_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic                           job_full,
	input  logic [wtm_pkg::OP_BITS-1:0]    op,
	input  logic [wtm_pkg::DELTA_BITS-1:0] data_delta,
	input  logic [wtm_pkg::TIME_BITS-1:0]  now_ms,
	input  logic [wtm_pkg::TOTAL_BITS-1:0] total_bytes,
	input  logic [wtm_pkg::CFG_BITS-1:0]   min_bytes,
	input  logic [wtm_pkg::CFG_BITS-1:0]   min_ms,
	output logic                           job_push,
	output logic                           job_divide,
	output logic [AMOUNT_BITS-1:0]         job_amount,
	output logic [wtm_pkg::TIME_BITS-1:0]  job_divisor
);

	logic [COUNT_BITS-1:0]          bytes_running_q;
	logic [COUNT_BITS-1:0]          bytes_at_sample_q;
	logic [wtm_pkg::TIME_BITS-1:0]  time_at_start_q;
	logic [wtm_pkg::TIME_BITS-1:0]  time_at_sample_q;

	logic                           accept;
	logic [COUNT_BITS:0]            sum;
	logic [COUNT_BITS-1:0]          bytes_added;
	logic [COUNT_BITS-1:0]          pending;
	logic [wtm_pkg::TIME_BITS-1:0]  since_sample;
	logic [wtm_pkg::TIME_BITS-1:0]  since_start;
	logic [wtm_pkg::TIME_BITS-1:0]  elapsed;
	logic                           take_sample;

	assign accept   = push && !job_full;
	assign job_push = accept;

	// The running count saturates rather than wrapping.
	assign sum          = {1'b0, bytes_running_q} + (COUNT_BITS+1)'(data_delta);
	assign bytes_added  = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
	assign pending      = bytes_added - bytes_at_sample_q;
	assign since_sample = now_ms - time_at_sample_q;
	assign since_start  = now_ms - time_at_start_q;
	assign take_sample  = (pending >= COUNT_BITS'(min_bytes)) && (since_sample >= min_ms);

	always_comb begin
		job_divide = 1'b0;
		job_amount = '0;
		elapsed    = since_sample;
		unique case (op)
			wtm_pkg::OP_ADD: begin
				if (take_sample) begin
					job_divide = 1'b1;
					job_amount = AMOUNT_BITS'(pending);
				end
			end
			wtm_pkg::OP_AVERAGE: begin
				job_divide = 1'b1;
				elapsed    = since_start;
				job_amount = (total_bytes == '0) ? AMOUNT_BITS'(bytes_running_q)
					: AMOUNT_BITS'(total_bytes);
			end
			default: begin
				job_divide = 1'b0;
			end
		endcase
		// A zero interval counts as one millisecond.
		job_divisor = (elapsed == '0) ? wtm_pkg::TIME_BITS'(1) : elapsed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_running_q   <= '0;
			bytes_at_sample_q <= '0;
			time_at_start_q   <= '0;
			time_at_sample_q  <= '0;
		end else if (accept) begin
			unique case (op)
				wtm_pkg::OP_START: begin
					bytes_running_q   <= '0;
					bytes_at_sample_q <= '0;
					time_at_start_q   <= now_ms;
					time_at_sample_q  <= now_ms;
				end
				wtm_pkg::OP_ADD: begin
					bytes_running_q <= bytes_added;
					if (take_sample) begin
						bytes_at_sample_q <= bytes_added;
						time_at_sample_q  <= now_ms;
					end
				end
				default: begin
					bytes_running_q <= bytes_running_q;
				end
			endcase
		end
	end

endmodule

// File: rtl/wtm_back.sv
// Back of the meter: takes jobs from the queue, forms amount*1000 and, for a
// job that asks for a rate, divides it by the interval one quotient bit a
// cycle, then holds the result. Depends on wtm_pkg.
`timescale 1ns / 1ps

module wtm_back #(
	parameter int AMOUNT_BITS = wtm_pkg::TOTAL_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_empty,
	input  logic                          job_divide,
	input  logic [AMOUNT_BITS-1:0]        job_amount,
	input  logic [wtm_pkg::TIME_BITS-1:0] job_divisor,
	output logic                          job_pop,
	input  logic                          pop,
	output logic                          empty,
	output logic                          rate_valid,
	output logic [wtm_pkg::RATE_BITS-1:0] rate_bytes_per_sec
);

	localparam int QW = AMOUNT_BITS + wtm_pkg::MS_BITS;
	localparam int CW = $clog2(QW);
	localparam int TW = wtm_pkg::TIME_BITS;

	wtm_pkg::bk_state_t state_q;
	wtm_pkg::bk_state_t state_d;

	logic [QW-1:0]  quot_q;
	logic [TW-1:0]  rem_q;
	logic [TW-1:0]  divisor_q;
	logic [CW-1:0]  step_q;
	logic           divide_q;
	logic           out_full_q;
	logic           out_valid_q;
	logic [wtm_pkg::RATE_BITS-1:0] out_rate_q;

	logic           out_free;
	logic           last_step;
	logic [QW-1:0]  amount_ms;
	logic [TW:0]    trial;
	logic           fits;
	logic [TW:0]    trial_diff;
	logic           saturate;
	logic [wtm_pkg::RATE_BITS-1:0] rate_sat;

	assign out_free  = !out_full_q || pop;
	assign last_step = (step_q == CW'(QW - 1));

	// The amount times 1000, formed as amount*1024 - amount*16 - amount*8.
	assign amount_ms = (QW'(job_amount) << 10) - (QW'(job_amount) << 4)
		- (QW'(job_amount) << 3);

	// Shift the next numerator bit into the partial remainder and try the divisor.
	assign trial      = {rem_q, quot_q[QW-1]};
	assign fits       = (trial >= {1'b0, divisor_q});
	assign trial_diff = trial - {1'b0, divisor_q};

	assign saturate = ((QW+1)'(quot_q) > (QW+1)'(wtm_pkg::RATE_MAX));
	assign rate_sat = saturate ? wtm_pkg::RATE_MAX : wtm_pkg::RATE_BITS'(quot_q);

	always_comb begin
		state_d = state_q;
		job_pop = 1'b0;
		unique case (state_q)
			wtm_pkg::BK_IDLE: begin
				if (!job_empty) begin
					job_pop = 1'b1;
					state_d = job_divide ? wtm_pkg::BK_DIV : wtm_pkg::BK_DONE;
				end
			end
			wtm_pkg::BK_DIV: begin
				if (last_step) begin
					state_d = wtm_pkg::BK_DONE;
				end
			end
			wtm_pkg::BK_DONE: begin
				if (out_free) begin
					state_d = wtm_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = wtm_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wtm_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Divider datapath.
	always_ff @(posedge clk) begin
		if (state_q == wtm_pkg::BK_IDLE && !job_empty) begin
			quot_q    <= job_divide ? amount_ms : '0;
			rem_q     <= '0;
			divisor_q <= job_divisor;
			step_q    <= '0;
			divide_q  <= job_divide;
		end else if (state_q == wtm_pkg::BK_DIV) begin
			quot_q <= {quot_q[QW-2:0], fits};
			rem_q  <= fits ? trial_diff[TW-1:0] : trial[TW-1:0];
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (state_q == wtm_pkg::BK_DONE && out_free) begin
			out_full_q <= 1'b1;
		end else if (pop) begin
			out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == wtm_pkg::BK_DONE && out_free) begin
			out_valid_q <= divide_q;
			out_rate_q  <= rate_sat;
		end
	end

	assign empty              = !out_full_q;
	assign rate_valid         = out_valid_q;
	assign rate_bytes_per_sec = out_rate_q;

endmodule

// File: rtl/windowed_throughput_meter.sv
// Top level of the windowed throughput meter: configuration registers, front,
// job queue and back. Depends on wtm_pkg, wtm_front, wtm_fifo and wtm_back.
//
//  Channel   Handshake         Payload
//  --------  ----------------  ----------------------------------------------
//  items     push / full       op, data_delta, now_ms, total_bytes
//  results   pop / empty       rate_valid, rate_bytes_per_sec
//  config    APB write / read  min_bytes at address 0, min_ms at address 4
//
// The front takes an item whenever the job queue has room and updates the
// counters at once. For an item that yields no rate the back steps from idle
// to done; for a rate it passes idle, the divide state and done, where the
// one-bit-per-cycle restoring divider works over the amount*1000 numerator.
// Results wait in a one-entry output register while the divider goes on with
// the next job; the job queue holds four items, so items are taken while a
// division runs. Reset clears counters, marks, registers and queues at once;
// no clearing pass is needed.
`timescale 1ns / 1ps

module windowed_throughput_meter #(
	parameter int COUNT_BITS = wtm_pkg::COUNT_BITS_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,

	// Items.
	input  logic                           push,
	output logic                           full,
	input  logic [wtm_pkg::OP_BITS-1:0]    op,
	input  logic [wtm_pkg::DELTA_BITS-1:0] data_delta,
	input  logic [wtm_pkg::TIME_BITS-1:0]  now_ms,
	input  logic [wtm_pkg::TOTAL_BITS-1:0] total_bytes,

	// Results.
	input  logic                           pop,
	output logic                           empty,
	output logic                           rate_valid,
	output logic [wtm_pkg::RATE_BITS-1:0]  rate_bytes_per_sec,

	// Configuration.
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [wtm_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [wtm_pkg::CFG_BITS-1:0]   pwdata,
	output logic [wtm_pkg::CFG_BITS-1:0]   prdata,
	output logic                           pready
);

	// The amount divided is either the running count or the query total,
	// whichever is wider.
	localparam int AMOUNT_BITS = (COUNT_BITS > wtm_pkg::TOTAL_BITS) ? COUNT_BITS
		: wtm_pkg::TOTAL_BITS;
	localparam int JOB_BITS = 1 + AMOUNT_BITS + wtm_pkg::TIME_BITS;

	logic [wtm_pkg::CFG_BITS-1:0] min_bytes_q;
	logic [wtm_pkg::CFG_BITS-1:0] min_ms_q;
	logic                         cfg_write;
	logic                         reg_sel;

	logic                          job_push;
	logic                          job_divide_in;
	logic [AMOUNT_BITS-1:0]        job_amount_in;
	logic [wtm_pkg::TIME_BITS-1:0] job_divisor_in;
	logic                          job_full;
	logic                          job_empty;
	logic                          job_pop;
	logic [JOB_BITS-1:0]           job_wdata;
	logic [JOB_BITS-1:0]           job_rdata;
	logic                          job_divide_out;
	logic [AMOUNT_BITS-1:0]        job_amount_out;
	logic [wtm_pkg::TIME_BITS-1:0] job_divisor_out;

	// The port never waits; bit 2 of the byte address picks the register.
	assign pready    = 1'b1;
	assign reg_sel   = paddr[2];
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (reg_sel == wtm_pkg::REG_MIN_MS) ? min_ms_q : min_bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_bytes_q <= '0;
			min_ms_q    <= '0;
		end else if (cfg_write) begin
			unique case (reg_sel)
				wtm_pkg::REG_MIN_BYTES: min_bytes_q <= pwdata;
				wtm_pkg::REG_MIN_MS:    min_ms_q    <= pwdata;
				default:                min_ms_q    <= min_ms_q;
			endcase
		end
	end

	// The item side is full exactly when the job queue is.
	assign full = job_full;

	wtm_front #(
		.COUNT_BITS  (COUNT_BITS),
		.AMOUNT_BITS (AMOUNT_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.job_full    (job_full),
		.op          (op),
		.data_delta  (data_delta),
		.now_ms      (now_ms),
		.total_bytes (total_bytes),
		.min_bytes   (min_bytes_q),
		.min_ms      (min_ms_q),
		.job_push    (job_push),
		.job_divide  (job_divide_in),
		.job_amount  (job_amount_in),
		.job_divisor (job_divisor_in)
	);

	assign job_wdata = {job_divide_in, job_amount_in, job_divisor_in};
	assign {job_divide_out, job_amount_out, job_divisor_out} = job_rdata;

	wtm_fifo #(
		.WIDTH (JOB_BITS),
		.DEPTH (wtm_pkg::JOB_QUEUE_DEPTH)
	) u_job_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wdata  (job_wdata),
		.rd_en  (job_pop),
		.rdata  (job_rdata),
		.full   (job_full),
		.empty  (job_empty)
	);

	wtm_back #(
		.AMOUNT_BITS (AMOUNT_BITS)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.job_empty          (job_empty),
		.job_divide         (job_divide_out),
		.job_amount         (job_amount_out),
		.job_divisor        (job_divisor_out),
		.job_pop            (job_pop),
		.pop                (pop),
		.empty              (empty),
		.rate_valid         (rate_valid),
		.rate_bytes_per_sec (rate_bytes_per_sec)
	);

endmodule
